// ----- rtl/hexagon_pixel_mask_assert.svh -----
// assertion macros shared by the hexagon pixel mask checker
// depends on nothing; expects i_clk and i_rst_n in the scope of use
`ifndef HEXAGON_PIXEL_MASK_ASSERT_SVH
`define HEXAGON_PIXEL_MASK_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hpm_pkg.sv -----
// shared constants for the hexagon pixel mask block
// used by hpm_dot, hexagon_pixel_mask and hpm_chk
package hpm_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int NUM_FACES      = 6;
    localparam int DIR_W          = 16;   // one Q1.14 direction component
    localparam int DIST_W         = 24;   // Q10.14 distance
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int OUT_W          = 8;    // in_hex, on_ring, half_bits

    localparam logic [CFG_IDX_W-1:0] REG_DIR0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR5       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_APOTHEM    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd7;

endpackage

// ----- rtl/hpm_dot.sv -----
// one face dot product, two register stages: products, then sum
// depends on hpm_pkg
module hpm_dot #(
    parameter int COORD_BITS = hpm_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [COORD_BITS-1:0]          i_px,
    input  logic signed [COORD_BITS-1:0]          i_py,
    input  logic        [hpm_pkg::CFG_W-1:0]      i_dir_xy,
    output logic signed [hpm_pkg::DIR_W+COORD_BITS:0] o_dot
);
    import hpm_pkg::*;

    localparam int PW = DIR_W + COORD_BITS;
    localparam int DW = PW + 1;

    logic signed [DIR_W-1:0] ux;
    logic signed [DIR_W-1:0] uy;
    logic signed [PW-1:0]    r_prod_x;
    logic signed [PW-1:0]    r_prod_y;
    logic signed [DW-1:0]    r_dot;

    assign ux = $signed(i_dir_xy[DIR_W-1:0]);
    assign uy = $signed(i_dir_xy[2*DIR_W-1:DIR_W]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x <= PW'(ux * i_px);
            r_prod_y <= PW'(uy * i_py);
            r_dot    <= DW'(r_prod_x) + DW'(r_prod_y);
        end
    end

    assign o_dot = r_dot;

endmodule

// ----- rtl/hexagon_pixel_mask.sv -----
// pipeline: offsets, products, sums, per-face compares, result register; one beat per
// cycle while the output is not stalled; the whole five-stage pipeline advances whenever
// the output register is empty or being taken, so o_s_tready = !o_m_tvalid | i_m_tready
// reset: synchronous active-low i_rst_n clears stage valids and all config registers
// (zero directions classify every pixel as inside with all half bits set)
// depends on hpm_pkg and hpm_dot
module hexagon_pixel_mask #(
    parameter int COORD_BITS = hpm_pkg::COORD_BITS_DEF,
    parameter int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [hpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hpm_pkg::CFG_W-1:0]         i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [IN_W-1:0]                   i_s_tdata,  // dx_offset, dy_offset, zero pad
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [hpm_pkg::OUT_W-1:0]         o_m_tdata   // in_hex, on_ring, half_bits[5:0]
);
    import hpm_pkg::*;

    localparam int DW = DIR_W + COORD_BITS + 1;
    localparam int CW = ((DW > DIST_W + 1) ? DW : DIST_W + 1) + 1;

    logic [CFG_W-1:0]  r_dir [NUM_FACES];
    logic [DIST_W-1:0] r_apothem;
    logic [DIST_W-1:0] r_line_width;

    logic                         en;
    logic [4:0]                   r_vld;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic signed [DW-1:0]         dot [NUM_FACES];

    logic signed [DIST_W:0]       diff;
    logic [DIST_W-1:0]            inner;
    logic signed [CW-1:0]         outer_c;
    logic signed [CW-1:0]         inner_c;
    logic signed [CW-1:0]         dot_c [NUM_FACES];

    logic [NUM_FACES-1:0] n_pos, n_peak, n_lo, n_li;
    logic [NUM_FACES-1:0] r_pos, r_peak, r_lo, r_li;
    logic [NUM_FACES-1:0] hit_outer, hit_inner;
    logic                 in_outer, in_inner;
    logic [OUT_W-1:0]     n_out;
    logic [OUT_W-1:0]     r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FACES; k++) begin
                r_dir[k] <= '0;
            end
            r_apothem    <= '0;
            r_line_width <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_APOTHEM:    r_apothem    <= i_cfg_data[DIST_W-1:0];
                REG_LINE_WIDTH: r_line_width <= i_cfg_data[DIST_W-1:0];
                default: begin
                    if (i_cfg_idx <= REG_DIR5) begin
                        r_dir[i_cfg_idx - REG_DIR0] <= i_cfg_data;
                    end
                end
            endcase
        end
    end

    // inner apothem falls back to the apothem when the inner hexagon would be empty
    assign diff    = $signed({1'b0, r_apothem}) - $signed({1'b0, r_line_width});
    assign inner   = (diff <= 0) ? r_apothem : diff[DIST_W-1:0];
    assign outer_c = $signed({{(CW - DIST_W){1'b0}}, r_apothem});
    assign inner_c = $signed({{(CW - DIST_W){1'b0}}, inner});

    assign en         = !r_vld[4] || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], i_s_tvalid};
        end
    end

    // stage 1: offsets
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= $signed(i_s_tdata[COORD_BITS-1:0]);
            r_py <= $signed(i_s_tdata[2*COORD_BITS-1:COORD_BITS]);
        end
    end

    // stages 2 and 3: six dot products in parallel
    for (genvar g = 0; g < NUM_FACES; g++) begin : g_face
        hpm_dot #(
            .COORD_BITS(COORD_BITS)
        ) u_dot (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_px     (r_px),
            .i_py     (r_py),
            .i_dir_xy (r_dir[g]),
            .o_dot    (dot[g])
        );
        assign dot_c[g] = $signed({{(CW - DW){dot[g][DW-1]}}, dot[g]});
    end

    // stage 4: per-face compares
    always_comb begin
        for (int k = 0; k < NUM_FACES; k++) begin
            n_pos[k]  = !dot[k][DW-1];
            n_peak[k] = (dot[k] >= dot[(k + NUM_FACES - 1) % NUM_FACES]) &&
                        (dot[k] >= dot[(k + 1) % NUM_FACES]);
            n_lo[k]   = dot_c[k] <= outer_c;
            n_li[k]   = dot_c[k] <= inner_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos  <= n_pos;
            r_peak <= n_peak;
            r_lo   <= n_lo;
            r_li   <= n_li;
        end
    end

    // stage 5: reduce to the result beat
    assign hit_outer = r_pos & r_peak & r_lo;
    assign hit_inner = r_pos & r_peak & r_li;
    assign in_outer  = |hit_outer;
    assign in_inner  = |hit_inner;
    assign n_out     = {(in_outer ? r_pos : {NUM_FACES{1'b0}}),
                        in_outer && !in_inner, in_outer};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_vld[4];
    assign o_m_tdata  = r_out;

endmodule

// ----- rtl/hpm_chk.sv -----
// port-level checker for hexagon_pixel_mask, attached by bind
// depends on hpm_pkg and hexagon_pixel_mask_assert.svh
`include "hexagon_pixel_mask_assert.svh"

module hpm_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_s_tready,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [hpm_pkg::OUT_W-1:0] o_m_tdata
);
    import hpm_pkg::*;

    // a stalled result beat holds
    `HPM_ASSERT_NEXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")
    // pipeline advances exactly when the output slot frees up
    `HPM_ASSERT_NOW(a_ready, 1'b1, o_s_tready == (!o_m_tvalid || i_m_tready), "input ready disagrees with output slot")
    // inside iff some half bit is set
    `HPM_ASSERT_NOW(a_half, o_m_tvalid, o_m_tdata[0] == (o_m_tdata[7:2] != 6'd0), "half bits inconsistent with in_hex")
    // ring pixels are inside the outer hexagon
    `HPM_ASSERT_NOW(a_ring, o_m_tvalid && o_m_tdata[1], o_m_tdata[0], "on_ring set outside hexagon")

endmodule

bind hexagon_pixel_mask hpm_chk u_hpm_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
